FILE: hdl/lfsd_pkg.sv
// Shared types, constants and digit decode for the LCD frame status decoder.
`timescale 1ns / 1ps
`default_nettype none

package lfsd_pkg;

    // Display modes
    localparam logic [4:0] MODE_OFF          = 5'd0;
    localparam logic [4:0] MODE_SET_CLOCK    = 5'd1;
    localparam logic [4:0] MODE_LOCKED       = 5'd2;
    localparam logic [4:0] MODE_SET_TEMP     = 5'd3;
    localparam logic [4:0] MODE_SET_VACATION = 5'd4;
    localparam logic [4:0] MODE_INFO_FIRST   = 5'd5;
    localparam logic [4:0] MODE_UNLOCKED     = 5'd16;

    // Seven-segment digit codes: 0..9 are the digit values
    localparam logic [3:0] DIG_MAX   = 4'd9;
    localparam logic [3:0] DIG_BLANK = 4'd10;
    localparam logic [3:0] DIG_MINUS = 4'd11;
    localparam logic [3:0] DIG_ERROR = 4'd12;

    // Info pages: masked word from bytes 10..13
    localparam int          INFO_COUNT = 11;
    localparam logic [31:0] INFO_MASK  = 32'h70FE_FEFE;
    localparam logic [31:0] INFO_WORDS [INFO_COUNT] = '{
        32'h008E_D6EA,  // SU
        32'h008E_D68A,  // SL
        32'h0000_8EF4,  // T3
        32'h0000_8E66,  // T4
        32'h0000_8E3E,  // TP
        32'h0000_8E4E,  // Th
        32'h0000_9A9E,  // CE
        32'h0060_0000,  // ER1
        32'h00BC_0000,  // ER2
        32'h00F4_0000,  // ER3
        32'h00EC_701E   // D7F
    };

    localparam int IN_W  = 128;
    localparam int OUT_W = 24;

    // Stage 1 -> stage 2
    typedef struct packed {
        logic                  off;
        logic                  set_clock;
        logic                  locked;
        logic                  set_temp;
        logic                  set_vacation;
        logic [INFO_COUNT-1:0] info_hit;
        logic [3:0]            ones;
        logic [3:0]            tens;
        logic                  hot;
        logic                  heater;
        logic                  pump;
        logic                  vacation;
    } t_s1;

    // Stage 2 -> stage 3
    typedef struct packed {
        logic [4:0]        mode;
        logic signed [7:0] temperature;
        logic              temp_valid;
        logic              hot;
        logic              heater;
        logic              pump;
        logic              vacation;
        logic              flags_valid;
    } t_s2;

    // Segment pattern to digit code; bit 0 of the pattern is a don't-care.
    function automatic logic [3:0] seg_digit(input logic [7:0] pattern);
        logic [3:0] code;
        unique case (pattern & 8'hFE)
            8'h00:   code = DIG_BLANK;
            8'h04:   code = DIG_MINUS;
            8'hFA:   code = 4'd0;
            8'h60:   code = 4'd1;
            8'hBC:   code = 4'd2;
            8'hF4:   code = 4'd3;
            8'h66:   code = 4'd4;
            8'hD6:   code = 4'd5;
            8'hDE:   code = 4'd6;
            8'h70:   code = 4'd7;
            8'hFE:   code = 4'd8;
            8'hF6:   code = 4'd9;
            default: code = DIG_ERROR;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/lcd_frame_status_decoder.sv
// Top level: three-stage LCD frame status decoder with stream handshakes.
//
//  channel  | dir | width | contents
//  ---------+-----+-------+-----------------------------------------------
//  s (in)   | in  | 128   | frame_low[63:0], frame_high[127:64]
//  m (out)  | out | 24    | mode, temperature, temp_valid, four flags,
//           |     |       | flags_valid, zero pad
//
// One item per cycle sustained while the output is not stalled; an accepted
// item passes the decode, resolve and output registers in that order, and
// o_m_tvalid rises once it is in the output register.
// Each stage holds its own valid bit; a stage loads when it is empty or the
// stage after it moves, so bubbles close up and the input keeps taking
// items while a result waits on the output, until all three stages are full.
// Synchronous active-low reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module lcd_frame_status_decoder (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_s_tvalid,
    output logic                        o_s_tready,
    // [63:0] frame_low, [127:64] frame_high
    input  wire  [lfsd_pkg::IN_W-1:0]   i_s_tdata,
    output logic                        o_m_tvalid,
    input  wire                         i_m_tready,
    // [4:0] mode, [12:5] temperature, [13] temp_valid, [14] hot_flag,
    // [15] heater_flag, [16] pump_flag, [17] vacation_flag, [18] flags_valid,
    // [23:19] zero
    output logic [lfsd_pkg::OUT_W-1:0]  o_m_tdata
);
    import lfsd_pkg::*;

    logic        w_rdy1;
    logic        w_rdy2;
    logic        w_rdy3;
    logic        w_v1;
    logic        w_v2;
    t_s1         w_s1;
    t_s2         w_s2;
    logic        r_v3;
    logic [OUT_W-1:0] r_data;
    logic [OUT_W-1:0] n_data;

    // Ready ripples back from the output register
    assign w_rdy3 = !r_v3 || i_m_tready;
    assign w_rdy2 = !w_v2 || w_rdy3;
    assign w_rdy1 = !w_v1 || w_rdy2;
    assign o_s_tready = w_rdy1;

    lfsd_seg_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_rdy1),
        .i_vld        (i_s_tvalid),
        .i_frame_low  (i_s_tdata[63:0]),
        .i_frame_high (i_s_tdata[127:64]),
        .o_vld        (w_v1),
        .o_s1         (w_s1)
    );

    lfsd_resolve u_resolve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_rdy2),
        .i_vld   (w_v1),
        .i_s1    (w_s1),
        .o_vld   (w_v2),
        .o_s2    (w_s2)
    );

    // Flags are only meaningful in locked / unlocked; force them low otherwise
    always_comb begin
        n_data        = '0;
        n_data[4:0]   = w_s2.mode;
        n_data[12:5]  = w_s2.temperature;
        n_data[13]    = w_s2.temp_valid;
        n_data[14]    = w_s2.hot      & w_s2.flags_valid;
        n_data[15]    = w_s2.heater   & w_s2.flags_valid;
        n_data[16]    = w_s2.pump     & w_s2.flags_valid;
        n_data[17]    = w_s2.vacation & w_s2.flags_valid;
        n_data[18]    = w_s2.flags_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= w_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && w_v2) begin
            r_data <= n_data;
        end
    end

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = r_data;

`ifndef ASSERT_OFF
    a_flags_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[18]) |-> (o_m_tdata[17:14] == 4'd0))
        else $error("indicator flags set outside locked/unlocked");

    a_flags_valid_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[18] ==
            ((o_m_tdata[4:0] == MODE_LOCKED) || (o_m_tdata[4:0] == MODE_UNLOCKED))))
        else $error("flags_valid disagrees with mode");

    a_temp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[13]) |-> (o_m_tdata[12:5] == 8'd0))
        else $error("invalid temperature not zero");

    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[4:0] <= MODE_UNLOCKED))
        else $error("mode out of range");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v1 && w_v2 && r_v3 && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted with full pipeline stalled");
`endif

endmodule

`default_nettype wire

FILE: hdl/lfsd_seg_decode.sv
// Stage 1: mode test bits, info page match and digit pattern decode.
`timescale 1ns / 1ps
`default_nettype none

module lfsd_seg_decode (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire                   i_vld,
    input  wire  [63:0]           i_frame_low,
    input  wire  [63:0]           i_frame_high,
    output logic                  o_vld,
    output lfsd_pkg::t_s1         o_s1
);
    import lfsd_pkg::*;

    logic          r_vld;
    t_s1           r_s1;
    t_s1           n_s1;
    logic [31:0]   w_word;
    logic [7:0]    w_ones_pat;
    logic [7:0]    w_tens_pat;

    assign w_word     = i_frame_high[47:16] & INFO_MASK;
    // byte3 low nibble, then byte4 top three bits, bit 0 unused
    assign w_ones_pat = {i_frame_low[27:24], i_frame_low[39:37], 1'b0};
    assign w_tens_pat = {i_frame_low[35:32], i_frame_low[47:45], 1'b0};

    always_comb begin
        n_s1.off          = (i_frame_low == 64'd0);
        n_s1.set_clock    = i_frame_high[47];
        n_s1.locked       = i_frame_high[56];
        n_s1.set_temp     = i_frame_low[52];
        n_s1.set_vacation = i_frame_low[60];
        for (int i = 0; i < INFO_COUNT; i++) begin
            n_s1.info_hit[i] = (w_word == INFO_WORDS[i]);
        end
        n_s1.ones     = seg_digit(w_ones_pat);
        n_s1.tens     = seg_digit(w_tens_pat);
        n_s1.hot      = i_frame_high[60];
        n_s1.heater   = i_frame_high[51];
        n_s1.pump     = i_frame_high[54];
        n_s1.vacation = i_frame_high[52];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_vld) begin
            r_s1 <= n_s1;
        end
    end

    assign o_vld = r_vld;
    assign o_s1  = r_s1;

endmodule

`default_nettype wire

FILE: hdl/lfsd_resolve.sv
// Stage 2: priority mode selection and temperature arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module lfsd_resolve (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire                   i_vld,
    input  lfsd_pkg::t_s1         i_s1,
    output logic                  o_vld,
    output lfsd_pkg::t_s2         o_s2
);
    import lfsd_pkg::*;

    logic        r_vld;
    t_s2         r_s2;
    t_s2         n_s2;
    logic [4:0]  w_info_mode;
    logic        w_info_any;
    logic [7:0]  w_tens8;
    logic [7:0]  w_ones8;
    logic [7:0]  w_two_digit;

    // Lowest matching page wins
    always_comb begin
        w_info_mode = MODE_UNLOCKED;
        w_info_any  = 1'b0;
        for (int i = INFO_COUNT - 1; i >= 0; i--) begin
            if (i_s1.info_hit[i]) begin
                w_info_mode = MODE_INFO_FIRST + 5'(i);
                w_info_any  = 1'b1;
            end
        end
    end

    assign w_tens8     = {4'd0, i_s1.tens};
    assign w_ones8     = {4'd0, i_s1.ones};
    assign w_two_digit = (w_tens8 << 3) + (w_tens8 << 1) + w_ones8;

    always_comb begin
        priority if (i_s1.off)          n_s2.mode = MODE_OFF;
        else if (i_s1.set_clock)        n_s2.mode = MODE_SET_CLOCK;
        else if (i_s1.locked)           n_s2.mode = MODE_LOCKED;
        else if (i_s1.set_temp)         n_s2.mode = MODE_SET_TEMP;
        else if (i_s1.set_vacation)     n_s2.mode = MODE_SET_VACATION;
        else if (w_info_any)            n_s2.mode = w_info_mode;
        else                            n_s2.mode = MODE_UNLOCKED;

        n_s2.temperature = 8'sd0;
        n_s2.temp_valid  = 1'b0;
        if (i_s1.ones <= DIG_MAX) begin
            if (i_s1.tens <= DIG_MAX) begin
                n_s2.temperature = w_two_digit;
                n_s2.temp_valid  = 1'b1;
            end else if (i_s1.tens == DIG_BLANK) begin
                n_s2.temperature = w_ones8;
                n_s2.temp_valid  = 1'b1;
            end else if (i_s1.tens == DIG_MINUS) begin
                n_s2.temperature = 8'd0 - w_ones8;
                n_s2.temp_valid  = 1'b1;
            end
        end

        n_s2.hot         = i_s1.hot;
        n_s2.heater      = i_s1.heater;
        n_s2.pump        = i_s1.pump;
        n_s2.vacation    = i_s1.vacation;
        n_s2.flags_valid = (n_s2.mode == MODE_LOCKED) || (n_s2.mode == MODE_UNLOCKED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_vld) begin
            r_s2 <= n_s2;
        end
    end

    assign o_vld = r_vld;
    assign o_s2  = r_s2;

endmodule

`default_nettype wire

FILE: tb/lfsd_status_checker.sv
// Checker for the LCD frame status decoder: predicts each frame's status and scores results.
`timescale 1ns / 1ps

module lfsd_status_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_s_tvalid,
    input  wire                          i_s_tready,
    // [63:0] frame_low, [127:64] frame_high
    input  wire  [lfsd_pkg::IN_W-1:0]    i_s_tdata,
    input  wire                          i_m_tvalid,
    input  wire                          i_m_tready,
    // [4:0] mode, [12:5] temperature, [13] temp_valid, [14] hot, [15] heater,
    // [16] pump, [17] vacation, [18] flags_valid, [23:19] zero
    input  wire  [lfsd_pkg::OUT_W-1:0]   i_m_tdata,
    output int                           o_fail_count,
    output int                           o_pending
);
    import lfsd_pkg::*;

    // Same bit order as the result item, MSB first
    typedef struct packed {
        logic [4:0]        pad;
        logic              flags_valid;
        logic              vacation;
        logic              pump;
        logic              heater;
        logic              hot;
        logic              temp_valid;
        logic signed [7:0] temperature;
        logic [4:0]        mode;
    } t_frame_status;

    t_frame_status expected_status_q [$];

    // Seven-segment pattern to digit code, bit 0 ignored
    function automatic logic [3:0] seg_value(input logic [7:0] pat);
        logic [3:0] code;
        case (pat & 8'hFE)
            8'h00:   code = DIG_BLANK;
            8'h04:   code = DIG_MINUS;
            8'hFA:   code = 4'd0;
            8'h60:   code = 4'd1;
            8'hBC:   code = 4'd2;
            8'hF4:   code = 4'd3;
            8'h66:   code = 4'd4;
            8'hD6:   code = 4'd5;
            8'hDE:   code = 4'd6;
            8'h70:   code = 4'd7;
            8'hFE:   code = 4'd8;
            8'hF6:   code = 4'd9;
            default: code = DIG_ERROR;
        endcase
        return code;
    endfunction

    function automatic t_frame_status predict_status(input logic [127:0] frame);
        logic [63:0]   lo;
        logic [63:0]   hi;
        logic [31:0]   word;
        logic [3:0]    ones;
        logic [3:0]    tens;
        t_frame_status st;
        lo = frame[63:0];
        hi = frame[127:64];
        st = '0;
        if (lo == 64'd0) begin
            st.mode = MODE_OFF;
        end else if (hi[47]) begin
            st.mode = MODE_SET_CLOCK;
        end else if (hi[56]) begin
            st.mode = MODE_LOCKED;
        end else if (lo[52]) begin
            st.mode = MODE_SET_TEMP;
        end else if (lo[60]) begin
            st.mode = MODE_SET_VACATION;
        end else begin
            st.mode = MODE_UNLOCKED;
            word = hi[47:16] & INFO_MASK;
            // walk backwards so the first page in the list wins
            for (int i = INFO_COUNT - 1; i >= 0; i--) begin
                if (word == INFO_WORDS[i])
                    st.mode = MODE_INFO_FIRST + 5'(i);
            end
        end

        // ones: byte3[3:0], byte4[7:5]; tens: byte4[3:0], byte5[7:5]
        ones = seg_value({lo[27:24], lo[39:37], 1'b0});
        tens = seg_value({lo[35:32], lo[47:45], 1'b0});
        if (ones <= DIG_MAX) begin
            if (tens <= DIG_MAX) begin
                st.temperature = 8'(tens * 10 + ones);
                st.temp_valid  = 1'b1;
            end else if (tens == DIG_BLANK) begin
                st.temperature = 8'(ones);
                st.temp_valid  = 1'b1;
            end else if (tens == DIG_MINUS) begin
                st.temperature = 8'(0 - ones);
                st.temp_valid  = 1'b1;
            end
        end

        st.flags_valid = (st.mode == MODE_LOCKED) || (st.mode == MODE_UNLOCKED);
        if (st.flags_valid) begin
            st.hot      = hi[60];
            st.heater   = hi[51];
            st.pump     = hi[54];
            st.vacation = hi[52];
        end
        return st;
    endfunction

    function automatic int field_differs(input string name, input int want, input int got);
        if (want == got)
            return 0;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_frame_status got;
        t_frame_status want;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_status_q.push_back(predict_status(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (expected_status_q.size() == 0) begin
                    $display("%0t ns: result with no frame pending, expected none, actual %h",
                             $time, i_m_tdata);
                    errs = 1;
                end else begin
                    want = expected_status_q.pop_front();
                    errs += field_differs("mode", want.mode, got.mode);
                    errs += field_differs("temperature", want.temperature, got.temperature);
                    errs += field_differs("temp_valid", want.temp_valid, got.temp_valid);
                    errs += field_differs("hot_flag", want.hot, got.hot);
                    errs += field_differs("heater_flag", want.heater, got.heater);
                    errs += field_differs("pump_flag", want.pump, got.pump);
                    errs += field_differs("vacation_flag", want.vacation, got.vacation);
                    errs += field_differs("flags_valid", want.flags_valid, got.flags_valid);
                    errs += field_differs("pad", want.pad, got.pad);
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending    <= expected_status_q.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// Top of the testbench: clock, reset, frame stimulus, output backpressure and verdict.
`timescale 1ns / 1ps

module testbench;
    import lfsd_pkg::*;

    // Cycles without any accepted item before the run is declared hung.
    // Worst natural gap is a long random idle run.
    localparam int STALL_LIMIT  = 2000;
    localparam int ITEMS_PHASE  = 520;
    localparam int DRAIN_CYCLES = 10;   // three-stage pipe plus margin

    // Legal segment patterns: digits 0..9, then blank, then minus
    localparam logic [7:0] SEG_TABLE [12] = '{
        8'hFA, 8'h60, 8'hBC, 8'hF4, 8'h66, 8'hD6, 8'hDE, 8'h70, 8'hFE, 8'hF6,
        8'h00, 8'h04
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;      // [63:0] frame_low, [127:64] frame_high
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;           // [4:0] mode ... [18] flags_valid, [23:19] zero
    int                fail_count;
    int                pending;
    int                s_idle_pct = 0;    // chance per draw that the sender idles before an item
    int                m_idle_pct = 0;    // chance per cycle that the receiver stalls
    int                frames_sent = 0;
    int                stall_cycles = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    lcd_frame_status_decoder u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    lfsd_status_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver backpressure: one draw per cycle, one assignment per edge
    always @(posedge clk) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= m_idle_pct);
    end

    // Hang detector: counts cycles where neither side moves an item
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Mostly a legal digit; now and then a random byte, usually an illegal one
    function automatic logic [7:0] pick_pattern();
        if ($urandom_range(7) == 0)
            return 8'($urandom);
        return SEG_TABLE[$urandom_range(11)];
    endfunction

    // Random frame steered into one display mode, with given digit patterns.
    // Priority bits above the target are cleared so the chain lands on it.
    function automatic logic [127:0] build_frame(input int target, input logic [7:0] ones_pat,
                                                 input logic [7:0] tens_pat);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [31:0] word;
        logic [31:0] flip;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        // digit fields sit in bytes 3..5
        lo[27:24] = ones_pat[7:4];
        lo[39:37] = ones_pat[3:1];
        lo[35:32] = tens_pat[7:4];
        lo[47:45] = tens_pat[3:1];
        if (target == MODE_OFF) begin
            lo = '0;
        end else begin
            if (target >= MODE_LOCKED)       hi[47] = 1'b0;
            if (target >= MODE_SET_TEMP)     hi[56] = 1'b0;
            if (target >= MODE_SET_VACATION) lo[52] = 1'b0;
            if (target >= MODE_INFO_FIRST)   lo[60] = 1'b0;
            if (target == MODE_SET_CLOCK)    hi[47] = 1'b1;
            if (target == MODE_LOCKED)       hi[56] = 1'b1;
            if (target == MODE_SET_TEMP)     lo[52] = 1'b1;
            if (target == MODE_SET_VACATION) lo[60] = 1'b1;
            if (target >= MODE_INFO_FIRST && target < MODE_UNLOCKED) begin
                // exact page word, free bits outside the mask random; bit 31 is set clock
                word = hi[47:16] & ~INFO_MASK & 32'h7FFF_FFFF;
                hi[47:16] = word | INFO_WORDS[target - MODE_INFO_FIRST];
            end else if (target == MODE_UNLOCKED && $urandom_range(1) == 1) begin
                // near miss: a page word with one masked bit flipped
                flip = INFO_MASK & (32'h1 << $urandom_range(31));
                if (flip == 32'd0)
                    flip = 32'h2;
                word = hi[47:16] & ~INFO_MASK & 32'h7FFF_FFFF;
                hi[47:16] = word | (INFO_WORDS[$urandom_range(INFO_COUNT - 1)] ^ flip);
            end
            if (lo == 64'd0)
                lo[0] = 1'b1;
        end
        return {hi, lo};
    endfunction

    // Offer one frame; returns at the edge where it is taken, tvalid still high
    task automatic send_frame(input logic [127:0] frame);
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= frame;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        frames_sent++;
    endtask

    // Hold the input off until every predicted result has come out
    task automatic drain_pause();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bit extremes, off with a busy upper half
        send_frame('0);
        send_frame('1);
        send_frame({64'hFFFF_FFFF_FFFF_FFFF, 64'd0});
        // every mode, every info page
        for (int t = MODE_SET_CLOCK; t <= MODE_UNLOCKED; t++)
            send_frame(build_frame(t, SEG_TABLE[$urandom_range(11)],
                                   SEG_TABLE[$urandom_range(11)]));
        // temperature corners
        send_frame(build_frame(MODE_UNLOCKED, 8'hF6, 8'hF6));  // 99
        send_frame(build_frame(MODE_LOCKED, 8'hF6, 8'h04));    // -9
        send_frame(build_frame(MODE_UNLOCKED, 8'hFA, 8'h04));  // minus zero
        send_frame(build_frame(MODE_SET_TEMP, 8'hFA, 8'h00));  // blank tens, zero
        send_frame(build_frame(MODE_UNLOCKED, 8'h02, 8'h60));  // bad ones digit
        send_frame(build_frame(MODE_LOCKED, 8'h60, 8'h08));    // bad tens digit
        send_frame(build_frame(MODE_UNLOCKED, 8'h04, 8'h00));  // minus in ones place
        drain_pause();

        // Random: three idle profiles, a full drain between them
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    s_idle_pct = 20;
                    m_idle_pct <= 78;
                end
                1: begin
                    s_idle_pct = 78;
                    m_idle_pct <= 20;
                end
                default: begin
                    s_idle_pct = 0;
                    m_idle_pct <= 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                if ($urandom_range(99) < 12)
                    send_frame({$urandom, $urandom, $urandom, $urandom});
                else
                    send_frame(build_frame($urandom_range(MODE_UNLOCKED), pick_pattern(),
                                           pick_pattern()));
            end
            drain_pause();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d frames: all display modes and info pages, near-miss pages,",
                 frames_sent);
        $display("signed, blank and invalid temperatures under three idle profiles");
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
hdl/lfsd_pkg.sv
hdl/lfsd_seg_decode.sv
hdl/lfsd_resolve.sv
hdl/lcd_frame_status_decoder.sv
tb/lfsd_status_checker.sv
tb/testbench.sv
